@@ rtl/brtu_pkg.sv @@
package brtu_pkg;

    localparam int IDX_W   = 25;
    localparam int DIM_W   = 14;
    localparam int ORG_W   = 13;
    localparam int TSL_W   = 2;
    localparam int CFG_W   = 14;
    localparam int CIDX_W  = 3;
    localparam int PIX_W   = 14;
    localparam int STAT_W  = 2;

    typedef enum logic [CIDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_X_ORIGIN     = 3'd2,
        REG_Y_ORIGIN     = 3'd3,
        REG_TU_SIZE_LOG2 = 3'd4
    } cfg_reg_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_END    = 2'd1,
        ST_BEYOND = 2'd2,
        ST_BADCFG = 2'd3
    } status_t;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 14'd1920;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 14'd1080;
    localparam logic [TSL_W-1:0] TU_SIZE_LOG2_RST = 2'd1;

endpackage

@@ rtl/block_raster_tu_coordinates_core.sv @@
// Channel  | handshake            | payload
// ---------+----------------------+-----------------------------------
// input    | in_valid / in_stall  | tu_number[24:0]
// output   | out_valid/ out_stall | pixel_x[13:0], pixel_y[13:0], status[1:0]
// config   | cfg_write            | cfg_index[2:0], cfg_data[13:0]
//
// One beat in and one beat out per cycle while out_stall is low; each accepted beat passes
// through capture, range check, three restoring dividers retiring one quotient bit per
// stage, setup and output adders.
// Reset clears the valid bits and loads the default registers.
// A stalled output beat freezes the whole pipeline; nothing is dropped.
module block_raster_tu_coordinates_core #(
    parameter int BLOCK_SIZE_LOG2 = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [brtu_pkg::IDX_W-1:0]    tu_number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [brtu_pkg::PIX_W-1:0]    pixel_x,
    output logic [brtu_pkg::PIX_W-1:0]    pixel_y,
    output logic [brtu_pkg::STAT_W-1:0]   status,
    input  logic                          cfg_write,
    input  logic [brtu_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [brtu_pkg::CFG_W-1:0]    cfg_data
);

    localparam int B   = BLOCK_SIZE_LOG2;
    localparam int Q1W = 14 - B;          // block row / column quotient bits
    localparam int Q3W = B - 1;           // TU row quotient bits
    localparam int DW  = 12 + B;          // widest divisor (TUs in a block row)
    localparam int CW  = DW + Q1W;        // divider compare width
    localparam int DMW = $clog2(B);       // bits of log2 TUs per block side
    localparam int S2  = Q1W + 2;
    localparam int S3  = S2 + Q1W + 1;
    localparam int S4  = S3 + Q3W + 1;
    localparam int NS  = S4 + 1;

    typedef struct packed {
        logic [brtu_pkg::STAT_W-1:0] status;
        logic [brtu_pkg::IDX_W-1:0]  rem;
        logic [Q1W-1:0]              quo;
        logic [DW-1:0]               dvs;
        logic                        dz;
        logic [Q1W-1:0]              brow;
        logic [Q1W-1:0]              bcol;
        logic [brtu_pkg::PIX_W-1:0]  px;
        logic [brtu_pkg::PIX_W-1:0]  py;
    } stage_t;

    logic [brtu_pkg::DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic [brtu_pkg::ORG_W-1:0] x_origin_reg, y_origin_reg;
    logic [brtu_pkg::TSL_W-1:0] tu_size_log2_reg;

    // derived geometry, refreshed every cycle from the registers
    logic                       bad_reg;
    logic [25:0]                total_reg;
    logic [DW-1:0]              row_tus_reg;
    logic [DW-1:0]              right_edge_reg, bottom_edge_reg;
    logic [DW-1:0]              blk_sz_reg, blk_side_reg;
    logic [Q1W-1:0]             whole_across_reg, whole_down_reg;

    logic                       bad_next;
    logic [DMW-1:0]             dims_next;
    logic [12:0]                across, down;
    logic [B-1:0]               bmask;

    stage_t                     pipe_reg  [NS];
    stage_t                     pipe_next [NS];
    logic   [NS-1:0]            valid_reg;
    logic                       advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= brtu_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= brtu_pkg::FRAME_HEIGHT_RST;
            x_origin_reg     <= '0;
            y_origin_reg     <= '0;
            tu_size_log2_reg <= brtu_pkg::TU_SIZE_LOG2_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                brtu_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                brtu_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                brtu_pkg::REG_X_ORIGIN:     x_origin_reg     <= cfg_data[brtu_pkg::ORG_W-1:0];
                brtu_pkg::REG_Y_ORIGIN:     y_origin_reg     <= cfg_data[brtu_pkg::ORG_W-1:0];
                brtu_pkg::REG_TU_SIZE_LOG2: tu_size_log2_reg <= cfg_data[brtu_pkg::TSL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        bmask     = '1;
        across    = 13'(frame_width_reg >> tu_size_log2_reg);
        down      = 13'(frame_height_reg >> tu_size_log2_reg);
        dims_next = DMW'(B) - DMW'(tu_size_log2_reg);
        bad_next  = (tu_size_log2_reg == 2'd0) || (tu_size_log2_reg == 2'd3)
                    || ((frame_width_reg[1:0] & {tu_size_log2_reg[1], 1'b1}) != 2'd0)
                    || ((frame_height_reg[1:0] & {tu_size_log2_reg[1], 1'b1}) != 2'd0);
    end

    always_ff @(posedge clk)
    begin
        bad_reg          <= bad_next;
        total_reg        <= 26'(across) * 26'(down);
        row_tus_reg      <= DW'(across) << dims_next;
        right_edge_reg   <= DW'(frame_width_reg[B-1:0] & bmask) >> tu_size_log2_reg;
        bottom_edge_reg  <= (DW'(frame_height_reg[B-1:0] & bmask) >> tu_size_log2_reg)
                            << dims_next;
        blk_sz_reg       <= DW'(1) << {dims_next, 1'b0};
        blk_side_reg     <= DW'(1) << dims_next;
        whole_across_reg <= Q1W'(frame_width_reg >> B);
        whole_down_reg   <= Q1W'(frame_height_reg >> B);
    end

    // one restoring step: retire quotient bit k
    function automatic stage_t div_step(stage_t p, int k);
        logic [CW-1:0] sh;
        sh = CW'(p.dvs) << k;
        if (CW'(p.rem) >= sh)
        begin
            p.rem = p.rem - brtu_pkg::IDX_W'(sh);
            p.quo = p.quo | (Q1W'(1) << k);
        end
        return p;
    endfunction

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (i == 0)
            begin
                pipe_next[i]     = '0;
                pipe_next[i].rem = tu_number;
            end
            else
            begin
                pipe_next[i] = pipe_reg[i-1];
                if (i == 1)
                begin
                    if (bad_reg)
                        pipe_next[i].status = brtu_pkg::ST_BADCFG;
                    else if ({1'b0, pipe_reg[i-1].rem} > total_reg)
                        pipe_next[i].status = brtu_pkg::ST_BEYOND;
                    else if (({1'b0, pipe_reg[i-1].rem} == total_reg) || (row_tus_reg == '0))
                        pipe_next[i].status = brtu_pkg::ST_END;
                    else
                        pipe_next[i].status = brtu_pkg::ST_OK;
                    pipe_next[i].dvs = row_tus_reg;
                    pipe_next[i].quo = '0;
                end
                else if (i < S2)
                begin
                    pipe_next[i] = div_step(pipe_reg[i-1], Q1W + 1 - i);
                end
                else if (i == S2)
                begin
                    pipe_next[i].brow = pipe_reg[i-1].quo;
                    pipe_next[i].dvs  = (pipe_reg[i-1].quo >= whole_down_reg)
                                        ? bottom_edge_reg : blk_sz_reg;
                    pipe_next[i].dz   = (pipe_next[i].dvs == '0);
                    pipe_next[i].quo  = '0;
                end
                else if (i < S3)
                begin
                    pipe_next[i] = div_step(pipe_reg[i-1], S2 + Q1W - i);
                end
                else if (i == S3)
                begin
                    // empty bottom edge: block column and TU offset are zero
                    pipe_next[i].bcol = pipe_reg[i-1].dz ? '0 : pipe_reg[i-1].quo;
                    pipe_next[i].rem  = pipe_reg[i-1].dz ? '0 : pipe_reg[i-1].rem;
                    pipe_next[i].dvs  = (pipe_next[i].bcol >= whole_across_reg)
                                        ? right_edge_reg : blk_side_reg;
                    pipe_next[i].dz   = (pipe_next[i].dvs == '0);
                    pipe_next[i].quo  = '0;
                end
                else if (i < S4)
                begin
                    pipe_next[i] = div_step(pipe_reg[i-1], S3 + Q3W - i);
                end
                else
                begin
                    if (pipe_reg[i-1].status != brtu_pkg::ST_OK)
                    begin
                        pipe_next[i].px = '0;
                        pipe_next[i].py = '0;
                    end
                    else
                    begin
                        pipe_next[i].px = (brtu_pkg::PIX_W'(pipe_reg[i-1].bcol) << B)
                            + (pipe_reg[i-1].dz ? brtu_pkg::PIX_W'(0)
                               : (brtu_pkg::PIX_W'(pipe_reg[i-1].rem) << tu_size_log2_reg))
                            + brtu_pkg::PIX_W'(x_origin_reg);
                        pipe_next[i].py = (brtu_pkg::PIX_W'(pipe_reg[i-1].brow) << B)
                            + (pipe_reg[i-1].dz ? brtu_pkg::PIX_W'(0)
                               : (brtu_pkg::PIX_W'(pipe_reg[i-1].quo) << tu_size_log2_reg))
                            + brtu_pkg::PIX_W'(y_origin_reg);
                    end
                end
            end
        end
    end

    // freeze every stage while the output beat is held
    assign advance  = !(valid_reg[NS-1] && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[NS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NS; i++)
                pipe_reg[i] <= pipe_next[i];
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign pixel_x   = pipe_reg[NS-1].px;
    assign pixel_y   = pipe_reg[NS-1].py;
    assign status    = pipe_reg[NS-1].status;

endmodule
